// ===== rtl/wsd_pkg.sv =====
package wsd_pkg;

    typedef enum logic [2:0] {
        PH_OPCODE  = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_OPCODE     = 2'd1,
        ERR_NOT_MASKED = 2'd2
    } err_code_t;

    localparam logic [7:0] OPCODE_RESET  = 8'h82;
    localparam logic       MASK_BIT_SET  = 1'b1;
    localparam logic [6:0] LEN7_EXT16    = 7'h7E;
    localparam logic [6:0] LEN7_EXT64    = 7'h7F;
    localparam logic [3:0] EXT16_BYTES   = 4'd2;
    localparam logic [3:0] EXT64_BYTES   = 4'd8;

    localparam int         APB_ADDR_W    = 2;
    localparam logic [APB_ADDR_W-1:0] ADDR_EXPECTED_OPCODE = 2'd0;

    typedef struct packed {
        logic      valid;
        logic [7:0] payload_byte;
        logic      frame_last;
        err_code_t error_code;
    } result_t;

endpackage

// ===== rtl/websocket_frame_deframer.sv =====
// Deframes a masked client-to-server WebSocket stream, one byte word per cycle
// unless stalled. An input word is registered, then decoded by the parser state
// machine once the output side can take its result; any unmasked payload byte or
// error lands in an output register, so a word can be accepted every cycle while
// the output is not stalled. Header, length and mask words produce no output word;
// a wrong opcode or an unmasked frame produces one error word and then all input
// is discarded until reset. Payload length uses the low 32 bits of the 64-bit form.
module websocket_frame_deframer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      in_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      payload_byte,
    output logic                            frame_last,
    output logic [1:0]                      error_code,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wsd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             out_valid_reg, out_valid_next;
    wsd_pkg::result_t out_reg;
    wsd_pkg::result_t step_result;
    logic [7:0]       expected_opcode;
    logic             advance;
    logic             in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    wsd_cfg u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .expected_opcode (expected_opcode)
    );

    wsd_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (advance),
        .in_byte         (in_byte_reg),
        .expected_opcode (expected_opcode),
        .result          (step_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = step_result.valid;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= in_byte;
        end
        if (advance && step_result.valid)
        begin
            out_reg <= step_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign payload_byte = out_reg.payload_byte;
    assign frame_last   = out_reg.frame_last;
    assign error_code   = out_reg.error_code;

endmodule

// ===== rtl/wsd_cfg.sv =====
module wsd_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wsd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [7:0]                      expected_opcode
);

    logic [7:0] opcode_reg;
    logic [7:0] opcode_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        opcode_next = opcode_reg;
        if (wr_en && (paddr == wsd_pkg::ADDR_EXPECTED_OPCODE))
        begin
            opcode_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opcode_reg <= wsd_pkg::OPCODE_RESET;
        end
        else
        begin
            opcode_reg <= opcode_next;
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr == wsd_pkg::ADDR_EXPECTED_OPCODE)
        begin
            prdata = {24'd0, opcode_reg};
        end
    end

    assign expected_opcode = opcode_reg;

endmodule

// ===== rtl/wsd_parser.sv =====
module wsd_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       in_byte,
    input  logic [7:0]       expected_opcode,
    output wsd_pkg::result_t result
);

    wsd_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  len_left_reg, len_left_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic [1:0]  mask_seen_reg, mask_seen_next;
    logic [1:0]  pay_phase_reg, pay_phase_next;
    logic        dead_reg, dead_next;
    logic [7:0]  mask_byte;
    logic [31:0] remaining_dec;

    assign remaining_dec = remaining_reg - 32'd1;

    always_comb
    begin
        case (pay_phase_reg)
            2'd0:    mask_byte = mask_key_reg[31:24];
            2'd1:    mask_byte = mask_key_reg[23:16];
            2'd2:    mask_byte = mask_key_reg[15:8];
            default: mask_byte = mask_key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        len_left_next  = len_left_reg;
        remaining_next = remaining_reg;
        mask_key_next  = mask_key_reg;
        mask_seen_next = mask_seen_reg;
        pay_phase_next = pay_phase_reg;
        dead_next      = dead_reg;
        if (step && !dead_reg)
        begin
            unique case (phase_reg)
                wsd_pkg::PH_LENGTH:
                begin
                    if (in_byte[7] != wsd_pkg::MASK_BIT_SET)
                    begin
                        dead_next = 1'b1;
                    end
                    else
                    begin
                        mask_seen_next = 2'd0;
                        remaining_next = 32'd0;
                        if (in_byte[6:0] == wsd_pkg::LEN7_EXT16)
                        begin
                            len_left_next = wsd_pkg::EXT16_BYTES;
                            phase_next    = wsd_pkg::PH_EXTLEN;
                        end
                        else if (in_byte[6:0] == wsd_pkg::LEN7_EXT64)
                        begin
                            len_left_next = wsd_pkg::EXT64_BYTES;
                            phase_next    = wsd_pkg::PH_EXTLEN;
                        end
                        else
                        begin
                            remaining_next = {25'd0, in_byte[6:0]};
                            phase_next     = wsd_pkg::PH_MASK;
                        end
                    end
                end
                wsd_pkg::PH_EXTLEN:
                begin
                    remaining_next = {remaining_reg[23:0], in_byte};
                    len_left_next  = len_left_reg - 4'd1;
                    if (len_left_next == 4'd0)
                    begin
                        mask_seen_next = 2'd0;
                        phase_next     = wsd_pkg::PH_MASK;
                    end
                end
                wsd_pkg::PH_MASK:
                begin
                    mask_key_next = {mask_key_reg[23:0], in_byte};
                    if (mask_seen_reg == 2'd3)
                    begin
                        mask_seen_next = 2'd0;
                        pay_phase_next = 2'd0;
                        phase_next     = (remaining_reg == 32'd0) ? wsd_pkg::PH_OPCODE
                                                                  : wsd_pkg::PH_PAYLOAD;
                    end
                    else
                    begin
                        mask_seen_next = mask_seen_reg + 2'd1;
                    end
                end
                wsd_pkg::PH_PAYLOAD:
                begin
                    pay_phase_next = pay_phase_reg + 2'd1;
                    remaining_next = remaining_dec;
                    if (remaining_dec == 32'd0)
                    begin
                        phase_next = wsd_pkg::PH_OPCODE;
                    end
                end
                default:
                begin
                    if (in_byte != expected_opcode)
                    begin
                        dead_next  = 1'b1;
                        phase_next = wsd_pkg::PH_OPCODE;
                    end
                    else
                    begin
                        phase_next = wsd_pkg::PH_LENGTH;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        result = '{valid: 1'b0, payload_byte: 8'd0, frame_last: 1'b0,
                   error_code: wsd_pkg::ERR_NONE};
        if (step && !dead_reg)
        begin
            unique case (phase_reg)
                wsd_pkg::PH_LENGTH:
                begin
                    if (in_byte[7] != wsd_pkg::MASK_BIT_SET)
                    begin
                        result.valid      = 1'b1;
                        result.error_code = wsd_pkg::ERR_NOT_MASKED;
                    end
                end
                wsd_pkg::PH_EXTLEN:
                begin
                end
                wsd_pkg::PH_MASK:
                begin
                end
                wsd_pkg::PH_PAYLOAD:
                begin
                    result.valid        = 1'b1;
                    result.payload_byte = in_byte ^ mask_byte;
                    result.frame_last   = (remaining_dec == 32'd0);
                end
                default:
                begin
                    if (in_byte != expected_opcode)
                    begin
                        result.valid      = 1'b1;
                        result.error_code = wsd_pkg::ERR_OPCODE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= wsd_pkg::PH_OPCODE;
            len_left_reg  <= 4'd0;
            remaining_reg <= 32'd0;
            mask_key_reg  <= 32'd0;
            mask_seen_reg <= 2'd0;
            pay_phase_reg <= 2'd0;
            dead_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            len_left_reg  <= len_left_next;
            remaining_reg <= remaining_next;
            mask_key_reg  <= mask_key_next;
            mask_seen_reg <= mask_seen_next;
            pay_phase_reg <= pay_phase_next;
            dead_reg      <= dead_next;
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 60;

    typedef enum int {
        FORM_SHORT,
        FORM_EXT16,
        FORM_EXT64
    } len_form_t;

    typedef struct {
        logic [7:0]         data;
        logic               last;
        wsd_pkg::err_code_t err;
    } deframed_word_t;

    class frame_tracker;
        logic [7:0]      opcode;
        wsd_pkg::phase_t phase;
        logic [3:0]      ext_left;
        logic [31:0]     remaining;
        logic [31:0]     key;
        logic [1:0]      key_seen;
        logic [1:0]      byte_idx;
        bit              dead;
        deframed_word_t  pending_words[$];
        int              fails;

        function new();
            opcode    = wsd_pkg::OPCODE_RESET;
            phase     = wsd_pkg::PH_OPCODE;
            ext_left  = '0;
            remaining = '0;
            key       = '0;
            key_seen  = '0;
            byte_idx  = '0;
            dead      = 1'b0;
            fails     = 0;
        endfunction

        function int waiting();
            return pending_words.size();
        endfunction

        function void push_word(logic [7:0] data, logic last, wsd_pkg::err_code_t err);
            deframed_word_t w;
            w.data = data;
            w.last = last;
            w.err  = err;
            pending_words.push_back(w);
        endfunction

        function void take_byte(logic [7:0] b);
            logic [7:0] data;
            logic       last;
            if (dead)
            begin
                return;
            end
            case (phase)
                wsd_pkg::PH_LENGTH:
                begin
                    if (b[7] != wsd_pkg::MASK_BIT_SET)
                    begin
                        dead = 1'b1;
                        push_word(8'h00, 1'b0, wsd_pkg::ERR_NOT_MASKED);
                    end
                    else
                    begin
                        remaining = '0;
                        key_seen  = '0;
                        if (b[6:0] == wsd_pkg::LEN7_EXT16)
                        begin
                            ext_left = wsd_pkg::EXT16_BYTES;
                            phase    = wsd_pkg::PH_EXTLEN;
                        end
                        else if (b[6:0] == wsd_pkg::LEN7_EXT64)
                        begin
                            ext_left = wsd_pkg::EXT64_BYTES;
                            phase    = wsd_pkg::PH_EXTLEN;
                        end
                        else
                        begin
                            remaining = {25'd0, b[6:0]};
                            phase     = wsd_pkg::PH_MASK;
                        end
                    end
                end
                wsd_pkg::PH_EXTLEN:
                begin
                    remaining = {remaining[23:0], b};
                    ext_left  = ext_left - 4'd1;
                    if (ext_left == 4'd0)
                    begin
                        key_seen = '0;
                        phase    = wsd_pkg::PH_MASK;
                    end
                end
                wsd_pkg::PH_MASK:
                begin
                    key = {key[23:0], b};
                    if (key_seen == 2'd3)
                    begin
                        key_seen = '0;
                        byte_idx = '0;
                        if (remaining == 32'd0)
                        begin
                            phase = wsd_pkg::PH_OPCODE;
                        end
                        else
                        begin
                            phase = wsd_pkg::PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        key_seen = key_seen + 2'd1;
                    end
                end
                wsd_pkg::PH_PAYLOAD:
                begin
                    data      = b ^ 8'(key >> (24 - 8 * int'(byte_idx)));
                    byte_idx  = byte_idx + 2'd1;
                    remaining = remaining - 32'd1;
                    last      = (remaining == 32'd0);
                    if (last)
                    begin
                        phase = wsd_pkg::PH_OPCODE;
                    end
                    push_word(data, last, wsd_pkg::ERR_NONE);
                end
                default:
                begin
                    if (b != opcode)
                    begin
                        dead  = 1'b1;
                        phase = wsd_pkg::PH_OPCODE;
                        push_word(8'h00, 1'b0, wsd_pkg::ERR_OPCODE);
                    end
                    else
                    begin
                        phase = wsd_pkg::PH_LENGTH;
                    end
                end
            endcase
        endfunction

        function void match_word(logic [7:0] data, logic last, logic [1:0] err);
            deframed_word_t w;
            if (pending_words.size() == 0)
            begin
                $error("Output word with nothing pending: %s %0h %s %0d %s %0d",
                       "payload_byte", data, "frame_last", last, "error_code", err);
                fails++;
                return;
            end
            w = pending_words.pop_front();
            if (data !== w.data)
            begin
                $error("payload_byte: expected %0h, got %0h", w.data, data);
                fails++;
            end
            if (last !== w.last)
            begin
                $error("frame_last: expected %0d, got %0d", w.last, last);
                fails++;
            end
            if (err !== w.err)
            begin
                $error("error_code: expected %0d, got %0d", w.err, err);
                fails++;
            end
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [7:0]                     in_byte = 8'h00;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [7:0]                     payload_byte;
    logic                           frame_last;
    logic [1:0]                     error_code;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [wsd_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    frame_tracker sb = new();

    int send_pct = 0;
    int recv_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int sent_bytes = 0;
    int quiet_cycles = 0;

    websocket_frame_deframer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .payload_byte (payload_byte),
        .frame_last   (frame_last),
        .error_code   (error_code),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_req != 0)
        begin
            hold_req  = 0;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= roll(recv_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.match_word(payload_byte, frame_last, error_code);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while (roll(send_pct))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.take_byte(b);
        sent_bytes++;
    endtask

    task automatic send_frame(input int unsigned len, input len_form_t form,
                              input logic [31:0] key);
        logic [31:0] upper;
        int          i;
        upper = $urandom;
        send_byte(sb.opcode);
        if (form == FORM_EXT16)
        begin
            send_byte({1'b1, wsd_pkg::LEN7_EXT16});
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end
        else if (form == FORM_EXT64)
        begin
            send_byte({1'b1, wsd_pkg::LEN7_EXT64});
            for (i = 0; i < 4; i++)
            begin
                send_byte(upper[31 - 8 * i -: 8]);
            end
            for (i = 0; i < 4; i++)
            begin
                send_byte(len[31 - 8 * i -: 8]);
            end
        end
        else
        begin
            send_byte({1'b1, len[6:0]});
        end
        for (i = 0; i < 4; i++)
        begin
            send_byte(key[31 - 8 * i -: 8]);
        end
        for (i = 0; i < int'(len); i++)
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_random_frame();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            send_frame($urandom_range(100, 125), FORM_SHORT, $urandom);
        end
        else if (pick < 70)
        begin
            send_frame($urandom_range(0, 12), FORM_SHORT, $urandom);
        end
        else if (pick < 85)
        begin
            send_frame($urandom_range(0, 20), FORM_EXT16, $urandom);
        end
        else
        begin
            send_frame($urandom_range(0, 20), FORM_EXT64, $urandom);
        end
    endtask

    task automatic run_stream(input int tx_pct, input int rx_pct, input int count);
        int target;
        send_pct = tx_pct;
        recv_pct = rx_pct;
        target   = sent_bytes + count;
        while (sent_bytes < target)
        begin
            send_random_frame();
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.waiting() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_opcode(input logic [7:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= wsd_pkg::ADDR_EXPECTED_OPCODE;
        pwdata  <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        sb.opcode = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic break_stream();
        int i;
        if ($urandom_range(0, 1) == 0)
        begin
            send_byte(sb.opcode ^ 8'($urandom_range(1, 255)));
        end
        else
        begin
            send_byte(sb.opcode);
            send_byte({1'b0, 7'($urandom_range(0, 127))});
        end
        for (i = 0; i < 6; i++)
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
        send_frame(2, FORM_SHORT, $urandom);
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        send_pct = 30;
        recv_pct = 72;
        send_frame(0, FORM_SHORT, $urandom);
        send_frame(1, FORM_SHORT, 32'hFFFF_FFFF);
        send_frame(2, FORM_EXT16, 32'h0000_0000);
        drain();

        write_opcode(8'hFF);
        run_stream(30, 72, 120);
        drain();

        write_opcode(8'h00);
        run_stream(72, 30, 120);
        drain();

        write_opcode(8'($urandom_range(1, 254)));
        run_stream(0, 0, 60);
        hold_req = 1;
        send_frame(40, FORM_SHORT, $urandom);
        run_stream(0, 0, 50);
        drain();

        write_opcode(wsd_pkg::OPCODE_RESET);
        break_stream();
        drain();
        repeat (8) @(posedge clk);

        if (sb.fails == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
